FILE: hdl/tbm_pkg.sv
// ----------------------------------------------------------------------------
// tbm_pkg
// Types and constants for the engine temperature bar monitor.
// ----------------------------------------------------------------------------
package tbm_pkg;

  localparam int DefSensors   = 4;
  localparam int DefBarHeight = 260;

  localparam int RegW   = 13;
  localparam int NRegs  = 8;
  localparam int ChW    = 3;
  localparam int CelW   = 12;
  localparam int FahW   = 13;
  localparam int HtW    = 9;
  localparam int LsW    = 16;
  localparam int AvgW   = 20;
  // working width for serial arithmetic
  localparam int WW     = 32;

  localparam logic signed [LsW-1:0] StartValue = -16'sd9999;
  localparam int HeadCold    = 180;
  localparam int ExhaustCold = 1200;
  localparam int SmallStep   = 4;
  localparam int TrendMargin = 10;

  localparam logic [2:0] RegHeadMin = 3'd0;
  localparam logic [2:0] RegHeadMax = 3'd1;
  localparam logic [2:0] RegExhMin  = 3'd2;
  localparam logic [2:0] RegExhMax  = 3'd3;
  localparam logic [2:0] RegHeadCau = 3'd4;
  localparam logic [2:0] RegHeadAlm = 3'd5;
  localparam logic [2:0] RegExhCau  = 3'd6;
  localparam logic [2:0] RegExhAlm  = 3'd7;

  localparam logic [1:0] LvlCold    = 2'd0;
  localparam logic [1:0] LvlNormal  = 2'd1;
  localparam logic [1:0] LvlCaution = 2'd2;
  localparam logic [1:0] LvlAlarm   = 2'd3;

  localparam logic [1:0] TrSteady  = 2'd0;
  localparam logic [1:0] TrRising  = 2'd1;
  localparam logic [1:0] TrFalling = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,   // wait for item
    S_READ,   // state entries registered
    S_CONV,   // divide 18C+325 by 10
    S_CHECK,  // small step test
    S_FILL,   // divide for fill height
    S_PEAK,   // divide for peak height
    S_AVG,    // divide for average
    S_WRITE,  // store state
    S_OUT     // result waits
  } state_t;

endpackage

FILE: hdl/temp_bar_monitor.sv
// ----------------------------------------------------------------------------
// temp_bar_monitor
// Converts Celsius samples to Fahrenheit bar display results per channel.
// ----------------------------------------------------------------------------
// channel  dir  fields (low bit up)
// s_axis   in   tdata: channel[2:0], temp_celsius[14:3]
// m_axis   out  tdata: bar_index, temp_fahrenheit, fill_height, alarm_level,
//                      trend, peak_height
// cfg      in   cfg_we, cfg_index, cfg_data
//
// An item with a result takes four passes of one bit-serial restoring divider
// (conversion, fill, peak, average), plus read, check, write, result and idle
// states. A small-step item skips fill and peak and gives no result. Reset is
// synchronous and restores registers and bar state. The result register holds
// while m_tready is low; s_tready is low while an item is in work.
module temp_bar_monitor
  import tbm_pkg::*;
#(
  parameter int SENSORS    = DefSensors,
  parameter int BAR_HEIGHT = DefBarHeight
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // channel[2:0], temp_celsius[14:3]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // bar_index[2:0], temp_fahrenheit[15:3],
                                 // fill_height[24:16], alarm_level[26:25],
                                 // trend[28:27], peak_height[37:29]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [RegW-1:0] cfg_data
);

  localparam int NBars = 2 * SENSORS;
  localparam int BW    = (NBars > 1) ? $clog2(NBars) : 1;
  localparam int CntW  = $clog2(WW + 1);

  logic signed [RegW-1:0] regs [NRegs];
  logic signed [LsW-1:0]  last_mem [NBars];
  logic signed [LsW-1:0]  peak_mem [NBars];
  logic signed [AvgW-1:0] avg_mem  [NBars];

  state_t state, state_next;

  logic [ChW-1:0]         ch;
  logic signed [CelW-1:0] cel;
  logic signed [LsW-1:0]  last_r, peak_r;
  logic signed [AvgW-1:0] avg_r;
  logic signed [FahW-1:0] f;
  logic [HtW-1:0]         fill, peakh;
  logic [1:0]             level, trend;
  logic                   small_step;

  // serial divider, non-negative operands, signs applied outside
  logic [WW-1:0]   dvd, dvs, quo, rem;
  logic [CntW-1:0] cnt;
  logic            neg;
  logic            dbusy;
  logic [WW:0]     trial;
  logic            dstart;
  logic signed [WW-1:0] st_num, st_den;
  logic [WW-1:0]   st_abs;

  logic head;
  logic signed [RegW-1:0] lo, hi, cau, alm;
  logic signed [WW-1:0] fw, pw, aw, qs;
  assign head = ~ch[0];
  assign lo  = head ? regs[RegHeadMin] : regs[RegExhMin];
  assign hi  = head ? regs[RegHeadMax] : regs[RegExhMax];
  assign cau = head ? regs[RegHeadCau] : regs[RegExhCau];
  assign alm = head ? regs[RegHeadAlm] : regs[RegExhAlm];
  assign fw  = WW'(f);
  assign pw  = WW'(peak_r);
  assign aw  = WW'(avg_r);
  assign qs  = neg ? -$signed(quo) : $signed(quo);

  // f and last_r stay stable from the end of conversion to the write
  assign small_step = (last_r != 0) && (LsW'(f) - last_r < SmallStep) &&
                      (last_r - LsW'(f) < SmallStep);

  assign s_tready = (state == S_IDLE);
  assign trial = {rem, dvd[WW-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[RegHeadMin] <= 13'sd100;
      regs[RegHeadMax] <= 13'sd400;
      regs[RegExhMin]  <= 13'sd750;
      regs[RegExhMax]  <= 13'sd1450;
      regs[RegHeadCau] <= 13'sd330;
      regs[RegHeadAlm] <= 13'sd361;
      regs[RegExhCau]  <= 13'sd1350;
      regs[RegExhAlm]  <= 13'sd1451;
    end else if (cfg_we) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (s_tvalid && int'(s_tdata[ChW-1:0]) < NBars) state_next = S_READ;
      S_READ:  state_next = S_CONV;
      S_CONV:  if (!dbusy && !dstart) state_next = S_CHECK;
      S_CHECK: state_next = small_step ? S_AVG : S_FILL;
      S_FILL:  if (!dbusy && !dstart) state_next = S_PEAK;
      S_PEAK:  if (!dbusy && !dstart) state_next = S_AVG;
      S_AVG:   if (!dbusy && !dstart) state_next = S_WRITE;
      S_WRITE: state_next = small_step ? S_IDLE : S_OUT;
      S_OUT:   if (m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // each divide state issues one start, then waits
  logic issued;
  always_comb begin
    st_num = '0;
    st_den = 32'sd1;
    case (state)
      S_CONV: begin
        st_num = 32'sd18 * WW'(cel) + 32'sd325;
        st_den = 32'sd10;
      end
      S_FILL: begin
        st_num = (fw - WW'(lo)) * BAR_HEIGHT;
        st_den = WW'(hi) - WW'(lo);
      end
      S_PEAK: begin
        st_num = (pw - WW'(lo)) * BAR_HEIGHT;
        st_den = WW'(hi) - WW'(lo);
      end
      S_AVG: begin
        st_num = aw * 10 + fw * 16;
        st_den = 32'sd11;
      end
      default: ;
    endcase
    st_abs = st_num[WW-1] ? WW'(-st_num) : WW'(st_num);
  end
  assign dstart = !issued && !dbusy &&
                  (state == S_CONV || state == S_FILL ||
                   state == S_PEAK || state == S_AVG);

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy  <= 1'b0;
      issued <= 1'b0;
    end else begin
      if (state != state_next) issued <= 1'b0;
      else if (dstart) issued <= 1'b1;
      if (dstart) begin
        dbusy <= 1'b1;
        dvd   <= st_abs;
        dvs   <= WW'(st_den);
        neg   <= st_num[WW-1];
        rem   <= '0;
        quo   <= '0;
        cnt   <= CntW'(WW);
      end else if (dbusy) begin
        if (!trial[WW]) begin
          rem <= trial[WW-1:0];
          quo <= {quo[WW-2:0], 1'b1};
        end else begin
          rem <= {rem[WW-2:0], dvd[WW-1]};
          quo <= {quo[WW-2:0], 1'b0};
        end
        dvd <= {dvd[WW-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) dbusy <= 1'b0;
      end
    end
  end

  function automatic logic [HtW-1:0] clamp_h(input logic signed [WW-1:0] v,
      input logic signed [RegW-1:0] l, input logic signed [RegW-1:0] h,
      input logic signed [WW-1:0] q);
    if (v <= WW'(l)) return '0;
    else if (v >= WW'(h)) return HtW'(BAR_HEIGHT);
    else return q[HtW-1:0];
  endfunction

  logic done;
  assign done = issued && !dbusy;
  logic [BW-1:0] bi;
  assign bi = BW'(ch);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NBars; i++) begin
        last_mem[i] <= StartValue;
        peak_mem[i] <= StartValue;
        avg_mem[i]  <= '0;
      end
    end else begin
      case (state)
        S_IDLE: if (s_tvalid) begin
          ch  <= s_tdata[ChW-1:0];
          cel <= s_tdata[ChW+CelW-1:ChW];
        end
        S_READ: begin
          last_r <= last_mem[bi];
          peak_r <= peak_mem[bi];
          avg_r  <= avg_mem[bi];
        end
        S_CONV: if (done) f <= qs[FahW-1:0];
        S_CHECK: begin
          if (fw <= WW'(ExhaustCold) && !head || fw <= WW'(HeadCold) && head)
            level <= LvlCold;
          else if (fw <= WW'(cau)) level <= LvlNormal;
          else if (fw <= WW'(alm)) level <= LvlCaution;
          else level <= LvlAlarm;
          if (aw > (fw + TrendMargin) * 16) trend <= TrFalling;
          else if (aw < (fw - TrendMargin) * 16) trend <= TrRising;
          else trend <= TrSteady;
          if (LsW'(f) > peak_r) peak_r <= LsW'(f);
        end
        S_FILL: if (done) fill <= clamp_h(fw, lo, hi, qs);
        S_PEAK: if (done) peakh <= clamp_h(pw, lo, hi, qs);
        S_AVG:  if (done) avg_r <= qs[AvgW-1:0];
        S_WRITE: begin
          avg_mem[bi] <= avg_r;
          if (!small_step) begin
            last_mem[bi] <= LsW'(f);
            peak_mem[bi] <= peak_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {2'b00, peakh, trend, level, fill, f, ch};

endmodule
